@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication that must hold in the cycle after the trigger.
`define CHK_NEXT(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

@@ rtl/stscan_pkg.sv @@
// Shared constants, token kinds and result entry type for the token scanner.
package stscan_pkg;

  // Width of the internal byte position and lexeme start counters.
  localparam int PosBits   = 16;
  // Width of the offset, length and line fields on the result stream.
  localparam int FieldBits = 16;
  localparam logic [FieldBits-1:0] FieldMax = '1;

  localparam int KindBits    = 5;
  localparam int OutDataBits = 56;
  localparam int InDataBits  = 8;

  // Token kinds.
  localparam logic [KindBits-1:0] KindLParen     = 5'd0;
  localparam logic [KindBits-1:0] KindRParen     = 5'd1;
  localparam logic [KindBits-1:0] KindLBrace     = 5'd2;
  localparam logic [KindBits-1:0] KindRBrace     = 5'd3;
  localparam logic [KindBits-1:0] KindComma      = 5'd4;
  localparam logic [KindBits-1:0] KindDot        = 5'd5;
  localparam logic [KindBits-1:0] KindMinus      = 5'd6;
  localparam logic [KindBits-1:0] KindPlus       = 5'd7;
  localparam logic [KindBits-1:0] KindSemicolon  = 5'd8;
  localparam logic [KindBits-1:0] KindStar       = 5'd9;
  localparam logic [KindBits-1:0] KindBang       = 5'd10;
  localparam logic [KindBits-1:0] KindEqual      = 5'd12;
  localparam logic [KindBits-1:0] KindLess       = 5'd14;
  localparam logic [KindBits-1:0] KindGreater    = 5'd16;
  localparam logic [KindBits-1:0] KindSlash      = 5'd18;
  localparam logic [KindBits-1:0] KindString     = 5'd19;
  localparam logic [KindBits-1:0] KindNumber     = 5'd20;
  localparam logic [KindBits-1:0] KindIdent      = 5'd21;
  localparam logic [KindBits-1:0] KindEnd        = 5'd22;
  localparam logic [KindBits-1:0] KindUnterm     = 5'd23;
  localparam logic [KindBits-1:0] KindUnexpected = 5'd24;

  typedef struct packed {
    logic [KindBits-1:0]  kind;
    logic [FieldBits-1:0] offset;
    logic [FieldBits-1:0] length;
    logic [FieldBits-1:0] line;
    logic                 last;
  } token_t;

  // Clamp a position-derived value (up to PosBits+1 bits) to the field width.
  function automatic logic [FieldBits-1:0] sat_field(input logic [PosBits:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (w > 33'(FieldMax)) begin
      return FieldMax;
    end else begin
      return w[FieldBits-1:0];
    end
  endfunction

endpackage

@@ rtl/source_token_scanner.sv @@
// Streaming lexical scanner: one source byte per transfer, tokens out.
// Output: a token enters the result queue with the transfer of the byte that completes
//   it; end of input flushes and adds the end token with that same transfer.
// Throughput: one byte per cycle while the 4-entry result queue holds at most one token;
//   a byte can give up to three tokens; the queue drains one per cycle when not stalled.
// Reset (rst_ni low, asynchronous): scanner idle, offset 0, line 1, result queue empty.
module source_token_scanner (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Source byte stream.
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [stscan_pkg::InDataBits-1:0]    s_axis_tdata_i,   // [7:0] char_code
  input  logic                                 s_axis_tlast_i,   // end_of_input
  // Token stream.
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [4:0] token_kind, [20:5] token_offset, [36:21] token_length,
  // [52:37] token_line, [55:53] zero
  output logic [stscan_pkg::OutDataBits-1:0]   m_axis_tdata_o,
  output logic                                 m_axis_tlast_o    // last_of_run
);

  localparam int PosBits = stscan_pkg::PosBits;
  localparam int LineBits = stscan_pkg::FieldBits;

  // Scan modes.
  localparam logic [3:0] ModeIdle    = 4'd0;
  localparam logic [3:0] ModeOper    = 4'd1;
  localparam logic [3:0] ModeSlash   = 4'd2;
  localparam logic [3:0] ModeComment = 4'd3;
  localparam logic [3:0] ModeString  = 4'd4;
  localparam logic [3:0] ModeInt     = 4'd5;
  localparam logic [3:0] ModeDot     = 4'd6;
  localparam logic [3:0] ModeFrac    = 4'd7;
  localparam logic [3:0] ModeIdent   = 4'd8;

  // Pending operator codes.
  localparam logic [2:0] OpNone    = 3'd0;
  localparam logic [2:0] OpBang    = 3'd1;
  localparam logic [2:0] OpEqual   = 3'd2;
  localparam logic [2:0] OpLess    = 3'd3;
  localparam logic [2:0] OpGreater = 3'd4;

  // Characters of interest.
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChLBrace  = 8'h7b;
  localparam logic [7:0] ChRBrace  = 8'h7d;
  localparam logic [7:0] ChComma   = 8'h2c;
  localparam logic [7:0] ChDot     = 8'h2e;
  localparam logic [7:0] ChMinus   = 8'h2d;
  localparam logic [7:0] ChPlus    = 8'h2b;
  localparam logic [7:0] ChSemi    = 8'h3b;
  localparam logic [7:0] ChStar    = 8'h2a;
  localparam logic [7:0] ChBang    = 8'h21;
  localparam logic [7:0] ChEqual   = 8'h3d;
  localparam logic [7:0] ChLess    = 8'h3c;
  localparam logic [7:0] ChGreater = 8'h3e;
  localparam logic [7:0] ChSlash   = 8'h2f;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [7:0] ChLowZ    = 8'h7a;
  localparam logic [7:0] ChUpA     = 8'h41;
  localparam logic [7:0] ChUpZ     = 8'h5a;
  localparam logic [7:0] ChUnder   = 8'h5f;

  // Result queue geometry.
  localparam int Depth   = 4;
  localparam int PtrBits = $clog2(Depth);
  localparam int CntBits = $clog2(Depth + 1);

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= ChZero) && (ch <= ChNine);
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return ((ch >= ChLowA) && (ch <= ChLowZ)) || ((ch >= ChUpA) && (ch <= ChUpZ)) ||
           (ch == ChUnder);
  endfunction

  // end - begin, or zero when end is not past begin.
  function automatic logic [PosBits:0] span(input logic [PosBits:0]   end_v,
                                            input logic [PosBits-1:0] begin_v);
    logic [PosBits:0] b;
    b = {1'b0, begin_v};
    return (end_v > b) ? (end_v - b) : '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Scanner state
  // ---------------------------------------------------------------------------
  logic [3:0]          mode_q, mode_d;
  logic [2:0]          pend_q, pend_d;
  logic [PosBits-1:0]  start_q, start_d;
  logic [PosBits-1:0]  pos_q, pos_d;
  logic [LineBits-1:0] line_q, line_d;

  logic [7:0] ch;
  logic       eoi;
  logic       in_xfer;

  assign ch      = s_axis_tdata_i;
  assign eoi     = s_axis_tlast_i;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // Up to three candidate tokens per byte: flushed token, trailing dot of a
  // number that ended on a dot, and the token this byte makes by itself.
  logic [2:0]                           tok_v;
  logic [stscan_pkg::KindBits-1:0]      tok_kind [3];
  logic [PosBits-1:0]                   tok_off  [3];
  logic [PosBits:0]                     tok_len  [3];

  logic [PosBits:0]                     pos_p1;
  logic [PosBits-1:0]                   dot_pos;
  logic [LineBits-1:0]                  line_inc;
  logic [stscan_pkg::KindBits-1:0]      oper_base;
  logic                                 flush_v0, flush_v1;
  logic [stscan_pkg::KindBits-1:0]      flush_kind;
  logic                                 do_flush, do_start;

  assign pos_p1   = {1'b0, pos_q} + 1'b1;
  assign dot_pos  = (pos_q > start_q) ? (pos_q - 1'b1) : start_q;
  assign line_inc = (line_q != '1) ? (line_q + 1'b1) : line_q;

  always_comb begin
    unique case (pend_q)
      OpEqual:   oper_base = stscan_pkg::KindEqual;
      OpLess:    oper_base = stscan_pkg::KindLess;
      OpGreater: oper_base = stscan_pkg::KindGreater;
      default:   oper_base = stscan_pkg::KindBang;
    endcase
  end

  // What the token in progress gives when something ends it.
  always_comb begin
    flush_v0   = 1'b1;
    flush_v1   = 1'b0;
    flush_kind = stscan_pkg::KindNumber;
    unique case (mode_q) inside
      ModeOper:            flush_kind = oper_base;
      ModeSlash:           flush_kind = stscan_pkg::KindSlash;
      ModeInt, ModeFrac:   flush_kind = stscan_pkg::KindNumber;
      ModeIdent:           flush_kind = stscan_pkg::KindIdent;
      ModeDot:             flush_v1   = 1'b1;
      default:             flush_v0   = 1'b0;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    start_d  = start_q;
    pos_d    = pos_q;
    line_d   = line_q;
    do_flush = 1'b0;
    do_start = 1'b0;
    tok_v    = '0;
    for (int i = 0; i < 3; i++) begin
      tok_kind[i] = stscan_pkg::KindEnd;
      tok_off[i]  = pos_q;
      tok_len[i]  = '0;
    end

    // Flushed token, in slots 0 and 1.
    tok_kind[0] = flush_kind;
    tok_off[0]  = start_q;
    tok_len[0]  = (mode_q == ModeDot) ? span({1'b0, dot_pos}, start_q)
                                      : span({1'b0, pos_q}, start_q);
    tok_kind[1] = stscan_pkg::KindDot;
    tok_off[1]  = dot_pos;
    tok_len[1]  = (PosBits+1)'(1);

    if (eoi) begin
      if (mode_q == ModeString) begin
        tok_v[0]    = 1'b1;
        tok_kind[0] = stscan_pkg::KindUnterm;
      end else begin
        tok_v[0] = flush_v0;
        tok_v[1] = flush_v1;
      end
      tok_v[2]    = 1'b1;
      tok_kind[2] = stscan_pkg::KindEnd;
      tok_off[2]  = pos_q;
      tok_len[2]  = '0;
      // Back to the reset state for the next source.
      mode_d  = ModeIdle;
      pend_d  = OpNone;
      start_d = '0;
      pos_d   = '0;
      line_d  = LineBits'(1);
    end else begin
      unique case (mode_q)
        ModeOper: begin
          if (ch == ChEqual) begin
            tok_v[2]    = 1'b1;
            tok_kind[2] = oper_base + 1'b1;
            tok_off[2]  = start_q;
            tok_len[2]  = span(pos_p1, start_q);
            mode_d      = ModeIdle;
            pend_d      = OpNone;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        ModeSlash: begin
          if (ch == ChSlash) begin
            mode_d = ModeComment;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        ModeComment: begin
          do_start = (ch == ChNewline);
        end
        ModeString: begin
          if (ch == ChQuote) begin
            tok_v[2]    = 1'b1;
            tok_kind[2] = stscan_pkg::KindString;
            tok_off[2]  = start_q;
            tok_len[2]  = span(pos_p1, start_q);
            mode_d      = ModeIdle;
          end else if (ch == ChNewline) begin
            line_d = line_inc;
          end
        end
        ModeInt: begin
          if (ch == ChDot) begin
            mode_d = ModeDot;
          end else if (!is_digit(ch)) begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        ModeDot: begin
          if (is_digit(ch)) begin
            mode_d = ModeFrac;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        ModeFrac: begin
          if (!is_digit(ch)) begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        ModeIdent: begin
          if (!(is_alpha(ch) || is_digit(ch))) begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      if (do_flush) begin
        tok_v[0] = flush_v0;
        tok_v[1] = flush_v1;
      end

      // A byte arriving between tokens.
      if (do_start) begin
        start_d     = pos_q;
        mode_d      = ModeIdle;
        pend_d      = OpNone;
        tok_off[2]  = pos_q;
        tok_len[2]  = (PosBits+1)'(1);
        unique case (ch) inside
          ChLParen:  begin tok_v[2] = 1'b1; tok_kind[2] = stscan_pkg::KindLParen;    end
          ChRParen:  begin tok_v[2] = 1'b1; tok_kind[2] = stscan_pkg::KindRParen;    end
          ChLBrace:  begin tok_v[2] = 1'b1; tok_kind[2] = stscan_pkg::KindLBrace;    end
          ChRBrace:  begin tok_v[2] = 1'b1; tok_kind[2] = stscan_pkg::KindRBrace;    end
          ChComma:   begin tok_v[2] = 1'b1; tok_kind[2] = stscan_pkg::KindComma;     end
          ChDot:     begin tok_v[2] = 1'b1; tok_kind[2] = stscan_pkg::KindDot;       end
          ChMinus:   begin tok_v[2] = 1'b1; tok_kind[2] = stscan_pkg::KindMinus;     end
          ChPlus:    begin tok_v[2] = 1'b1; tok_kind[2] = stscan_pkg::KindPlus;      end
          ChSemi:    begin tok_v[2] = 1'b1; tok_kind[2] = stscan_pkg::KindSemicolon; end
          ChStar:    begin tok_v[2] = 1'b1; tok_kind[2] = stscan_pkg::KindStar;      end
          ChBang:    begin mode_d = ModeOper; pend_d = OpBang;    end
          ChEqual:   begin mode_d = ModeOper; pend_d = OpEqual;   end
          ChLess:    begin mode_d = ModeOper; pend_d = OpLess;    end
          ChGreater: begin mode_d = ModeOper; pend_d = OpGreater; end
          ChSlash:   mode_d = ModeSlash;
          ChSpace, ChCr, ChTab: ;
          ChNewline: line_d = line_inc;
          ChQuote:   mode_d = ModeString;
          default: begin
            if (is_digit(ch)) begin
              mode_d = ModeInt;
            end else if (is_alpha(ch)) begin
              mode_d = ModeIdent;
            end else begin
              tok_v[2]    = 1'b1;
              tok_kind[2] = stscan_pkg::KindUnexpected;
            end
          end
        endcase
      end

      // Position stops at its maximum.
      pos_d = (pos_q != '1) ? pos_p1[PosBits-1:0] : pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      pend_q  <= OpNone;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= LineBits'(1);
    end else if (in_xfer) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: the valid candidates are written in order, one transfer
  // per cycle leaves at the head while the receiver is ready.
  // ---------------------------------------------------------------------------
  stscan_pkg::token_t entry [3];
  stscan_pkg::token_t fifo_q [Depth];

  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q, count_d;
  logic [1:0]         push_n;
  logic               pop;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      entry[i].kind   = tok_kind[i];
      entry[i].offset = stscan_pkg::sat_field({1'b0, tok_off[i]});
      entry[i].length = stscan_pkg::sat_field(tok_len[i]);
      entry[i].line   = line_q;
    end
    entry[0].last = tok_v[0] && !tok_v[1] && !tok_v[2];
    entry[1].last = tok_v[1] && !tok_v[2];
    entry[2].last = tok_v[2];
  end

  assign push_n  = in_xfer ? (2'(tok_v[0]) + 2'(tok_v[1]) + 2'(tok_v[2])) : 2'd0;
  assign pop     = m_axis_tvalid_o && m_axis_tready_i;
  assign count_d = count_q + CntBits'(push_n) - CntBits'(pop);

  // Room for a full three-token burst is guaranteed before a byte is taken.
  assign s_axis_tready_o = (count_q < CntBits'(Depth - 2));

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      if (tok_v[0]) begin
        fifo_q[wr_ptr_q] <= entry[0];
      end
      if (tok_v[1]) begin
        fifo_q[wr_ptr_q + PtrBits'(tok_v[0])] <= entry[1];
      end
      if (tok_v[2]) begin
        fifo_q[wr_ptr_q + PtrBits'(tok_v[0]) + PtrBits'(tok_v[1])] <= entry[2];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrBits'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrBits'(pop);
      count_q  <= count_d;
    end
  end

  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = {3'b000,
                            fifo_q[rd_ptr_q].line,
                            fifo_q[rd_ptr_q].length,
                            fifo_q[rd_ptr_q].offset,
                            fifo_q[rd_ptr_q].kind};
  assign m_axis_tlast_o  = fifo_q[rd_ptr_q].last;

endmodule

@@ rtl/stscan_chk.sv @@
// Port-level checker for the token scanner, bound to the top level.
`include "assert_macros.svh"

module stscan_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid_i,
  input logic                                s_axis_tready_o,
  input logic                                s_axis_tlast_i,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i,
  input logic [stscan_pkg::OutDataBits-1:0]  m_axis_tdata_o,
  input logic                                m_axis_tlast_o
);

  logic [stscan_pkg::KindBits-1:0]  kind;
  logic [stscan_pkg::FieldBits-1:0] length;
  logic [stscan_pkg::FieldBits-1:0] line;

  assign kind   = m_axis_tdata_o[4:0];
  assign length = m_axis_tdata_o[36:21];
  assign line   = m_axis_tdata_o[52:37];

  // A stalled token holds.
  `CHK_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "stalled token changed")

  // End of input always leaves at least the end token behind.
  `CHK_NEXT(a_eoi_token, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, m_axis_tvalid_o, "no token after end of input")

  // The end token is empty and closes its run.
  `CHK_ASSERT(a_end_shape, clk_i, rst_ni, m_axis_tvalid_o && (kind == stscan_pkg::KindEnd) |-> (length == '0) && m_axis_tlast_o, "bad end token")

  `CHK_ASSERT(a_kind_range, clk_i, rst_ni, m_axis_tvalid_o |-> (kind <= stscan_pkg::KindUnexpected) && (line != '0), "token kind or line out of range")

endmodule

bind source_token_scanner stscan_chk u_stscan_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

@@ tb/source_token_scanner_test.sv @@
// Self-checking stream testbench for the source token scanner.
`timescale 1ns / 1ps

module source_token_scanner_test;

  // Source bytes that steer the scanner.
  localparam logic [7:0] ChLParen  = "(";
  localparam logic [7:0] ChRParen  = ")";
  localparam logic [7:0] ChLBrace  = "{";
  localparam logic [7:0] ChRBrace  = "}";
  localparam logic [7:0] ChComma   = ",";
  localparam logic [7:0] ChDot     = ".";
  localparam logic [7:0] ChMinus   = "-";
  localparam logic [7:0] ChPlus    = "+";
  localparam logic [7:0] ChSemi    = ";";
  localparam logic [7:0] ChStar    = "*";
  localparam logic [7:0] ChBang    = "!";
  localparam logic [7:0] ChEqual   = "=";
  localparam logic [7:0] ChLess    = "<";
  localparam logic [7:0] ChGreater = ">";
  localparam logic [7:0] ChSlash   = "/";
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSpace   = " ";
  localparam logic [7:0] ChUnder   = "_";
  localparam logic [7:0] ChZero    = "0";
  localparam logic [7:0] ChNine    = "9";

  localparam int KindBits  = stscan_pkg::KindBits;
  localparam int FieldBits = stscan_pkg::FieldBits;

  localparam int unsigned PosMax     = (32'd1 << stscan_pkg::PosBits) - 1;
  localparam int          MaxTokens  = 3;
  localparam int          StallLimit = 5000;
  localparam int          ShownErrs  = 10;
  localparam int          TailCycles = 8;

  // Bit positions of the token fields in m_axis_tdata_o.
  localparam int OffLsb  = KindBits;
  localparam int LenLsb  = KindBits + FieldBits;
  localparam int LineLsb = KindBits + 2 * FieldBits;
  localparam int PadLsb  = KindBits + 3 * FieldBits;

  typedef enum logic [3:0] {
    ScanIdle, ScanOper, ScanSlash, ScanComment, ScanString,
    ScanInt, ScanDot, ScanFrac, ScanIdent
  } scan_mode_e;

  typedef enum logic [2:0] {OpNone, OpBang, OpEqual, OpLess, OpGreater} pend_op_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_byte_t;

  logic                                  clk_i = 1'b0;
  logic                                  rst_ni = 1'b0;
  logic                                  s_axis_tvalid_i = 1'b0;
  logic                                  s_axis_tready_o;
  logic [stscan_pkg::InDataBits-1:0]     s_axis_tdata_i = '0;
  logic                                  s_axis_tlast_i = 1'b0;
  logic                                  m_axis_tvalid_o;
  logic                                  m_axis_tready_i = 1'b0;
  logic [stscan_pkg::OutDataBits-1:0]    m_axis_tdata_o;
  logic                                  m_axis_tlast_o;

  source_token_scanner dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stimulus and scoreboard state.
  src_byte_t           source_bytes[$];
  stscan_pkg::token_t  pending_tokens[$];
  int unsigned bytes_queued   = 0;
  int unsigned bytes_accepted = 0;
  int unsigned tokens_checked = 0;
  int unsigned sources_sent   = 0;
  int unsigned err_count      = 0;
  int unsigned snd_idle_pct   = 0;
  int unsigned rcv_idle_pct   = 0;
  int unsigned stall_cycles   = 0;

  // Scanner state as the predictor tracks it.
  scan_mode_e          scan_mode  = ScanIdle;
  pend_op_e            pend_op    = OpNone;
  int unsigned         lex_start  = 0;
  int unsigned         byte_pos   = 0;
  int unsigned         line_no    = 1;
  stscan_pkg::token_t  step_tok[MaxTokens];
  int                  n_tok;

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic logic [FieldBits-1:0] clamp_field(input int unsigned v);
    return (v > stscan_pkg::FieldMax) ? stscan_pkg::FieldMax : v[FieldBits-1:0];
  endfunction

  function automatic int unsigned span(input int unsigned upto, input int unsigned from);
    return (upto > from) ? upto - from : 0;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == ChUnder;
  endfunction

  function automatic void bump_line();
    if (line_no < stscan_pkg::FieldMax) line_no++;
  endfunction

  function automatic void emit(input logic [KindBits-1:0] kind, input int unsigned off,
                               input int unsigned len);
    if (n_tok < MaxTokens) begin
      step_tok[n_tok] = '{kind: kind, offset: clamp_field(off), length: clamp_field(len),
                          line: clamp_field(line_no), last: 1'b0};
      n_tok++;
    end
  endfunction

  function automatic logic punct_kind(input logic [7:0] c, output logic [KindBits-1:0] k);
    k = stscan_pkg::KindLParen;
    punct_kind = 1'b1;
    case (c)
      ChLParen: k = stscan_pkg::KindLParen;
      ChRParen: k = stscan_pkg::KindRParen;
      ChLBrace: k = stscan_pkg::KindLBrace;
      ChRBrace: k = stscan_pkg::KindRBrace;
      ChComma:  k = stscan_pkg::KindComma;
      ChDot:    k = stscan_pkg::KindDot;
      ChMinus:  k = stscan_pkg::KindMinus;
      ChPlus:   k = stscan_pkg::KindPlus;
      ChSemi:   k = stscan_pkg::KindSemicolon;
      ChStar:   k = stscan_pkg::KindStar;
      default:  punct_kind = 1'b0;
    endcase
  endfunction

  // Paired form ("!=", "==", "<=", ">=") sits one above the single form.
  function automatic logic [KindBits-1:0] operator_kind(input logic paired);
    logic [KindBits-1:0] base;
    case (pend_op)
      OpEqual:   base = stscan_pkg::KindEqual;
      OpLess:    base = stscan_pkg::KindLess;
      OpGreater: base = stscan_pkg::KindGreater;
      default:   base = stscan_pkg::KindBang;
    endcase
    return base + KindBits'(paired);
  endfunction

  // Close the lexeme in progress; it ends just before position pos.
  function automatic void flush_lexeme(input int unsigned pos);
    int unsigned dot_at;
    case (scan_mode) inside
      ScanOper:  emit(operator_kind(1'b0), lex_start, span(pos, lex_start));
      ScanSlash: emit(stscan_pkg::KindSlash, lex_start, span(pos, lex_start));
      ScanInt, ScanFrac: emit(stscan_pkg::KindNumber, lex_start, span(pos, lex_start));
      ScanIdent: emit(stscan_pkg::KindIdent, lex_start, span(pos, lex_start));
      ScanDot: begin
        // number without fraction digit: the number, then the dot on its own
        dot_at = (pos > lex_start) ? pos - 1 : lex_start;
        emit(stscan_pkg::KindNumber, lex_start, span(dot_at, lex_start));
        emit(stscan_pkg::KindDot, dot_at, 1);
      end
      default: ;
    endcase
    scan_mode = ScanIdle;
    pend_op   = OpNone;
  endfunction

  // A byte seen between tokens.
  function automatic void open_lexeme(input logic [7:0] c, input int unsigned pos);
    logic [KindBits-1:0] k;
    lex_start = pos;
    scan_mode = ScanIdle;
    pend_op   = OpNone;
    if (punct_kind(c, k)) begin
      emit(k, pos, 1);
      return;
    end
    case (c) inside
      ChBang:    begin scan_mode = ScanOper; pend_op = OpBang; end
      ChEqual:   begin scan_mode = ScanOper; pend_op = OpEqual; end
      ChLess:    begin scan_mode = ScanOper; pend_op = OpLess; end
      ChGreater: begin scan_mode = ScanOper; pend_op = OpGreater; end
      ChSlash:   scan_mode = ScanSlash;
      ChSpace, ChCr, ChTab: ;
      ChNewline: bump_line();
      ChQuote:   scan_mode = ScanString;
      default: begin
        if (is_digit(c)) scan_mode = ScanInt;
        else if (is_alpha(c)) scan_mode = ScanIdent;
        else emit(stscan_pkg::KindUnexpected, pos, 1);
      end
    endcase
  endfunction

  function automatic void restart_scanner();
    scan_mode = ScanIdle;
    pend_op   = OpNone;
    lex_start = 0;
    byte_pos  = 0;
    line_no   = 1;
  endfunction

  // Advance the predictor by one accepted transfer and queue the tokens it gives.
  function automatic void scan_byte(input logic [7:0] c, input logic eoi);
    int unsigned        pos;
    stscan_pkg::token_t t;
    pos   = byte_pos;
    n_tok = 0;
    if (eoi) begin
      if (scan_mode == ScanString) emit(stscan_pkg::KindUnterm, lex_start, span(pos, lex_start));
      else flush_lexeme(pos);
      emit(stscan_pkg::KindEnd, pos, 0);
      restart_scanner();
    end else begin
      case (scan_mode) inside
        ScanOper: begin
          if (c == ChEqual) begin
            emit(operator_kind(1'b1), lex_start, span(pos + 1, lex_start));
            scan_mode = ScanIdle;
            pend_op   = OpNone;
          end else begin
            flush_lexeme(pos);
            open_lexeme(c, pos);
          end
        end
        ScanSlash: begin
          if (c == ChSlash) scan_mode = ScanComment;
          else begin
            flush_lexeme(pos);
            open_lexeme(c, pos);
          end
        end
        ScanComment: if (c == ChNewline) open_lexeme(c, pos);
        ScanString: begin
          if (c == ChQuote) begin
            emit(stscan_pkg::KindString, lex_start, span(pos + 1, lex_start));
            scan_mode = ScanIdle;
          end else if (c == ChNewline) bump_line();
        end
        ScanInt: begin
          if (c == ChDot) scan_mode = ScanDot;
          else if (!is_digit(c)) begin
            flush_lexeme(pos);
            open_lexeme(c, pos);
          end
        end
        ScanDot: begin
          if (is_digit(c)) scan_mode = ScanFrac;
          else begin
            flush_lexeme(pos);
            open_lexeme(c, pos);
          end
        end
        ScanFrac, ScanIdent: begin
          if (!(is_digit(c) || (scan_mode == ScanIdent && is_alpha(c)))) begin
            flush_lexeme(pos);
            open_lexeme(c, pos);
          end
        end
        default: open_lexeme(c, pos);
      endcase
      byte_pos = (pos < PosMax) ? pos + 1 : PosMax;
    end
    for (int i = 0; i < n_tok; i++) begin
      t      = step_tok[i];
      t.last = (i == n_tok - 1);
      pending_tokens.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds queued bytes, idles at random per snd_idle_pct
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : byte_driver
    src_byte_t nxt;
    if (rst_ni) begin
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (source_bytes.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          nxt = source_bytes.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= nxt.ch;
          s_axis_tlast_i  <= nxt.eoi;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks the token transfer first, then predicts from the byte transfer
  // of the same edge (a token never shows in the cycle its byte goes in).
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input stscan_pkg::token_t want,
                                 input stscan_pkg::token_t got);
    err_count++;
    if (err_count <= ShownErrs) begin
      $display("%0t: %s: expected kind %0d off %0d len %0d line %0d last %0b",
               $realtime, what, want.kind, want.offset, want.length, want.line, want.last);
      $display("  got kind %0d off %0d len %0d line %0d last %0b",
               got.kind, got.offset, got.length, got.line, got.last);
    end
  endtask

  always @(posedge clk_i) begin : token_monitor
    stscan_pkg::token_t want;
    stscan_pkg::token_t got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.kind   = m_axis_tdata_o[KindBits-1:0];
        got.offset = m_axis_tdata_o[OffLsb +: FieldBits];
        got.length = m_axis_tdata_o[LenLsb +: FieldBits];
        got.line   = m_axis_tdata_o[LineLsb +: FieldBits];
        got.last   = m_axis_tlast_o;
        tokens_checked++;
        if (pending_tokens.size() == 0) begin
          want = '0;
          report_mismatch("token with none expected", want, got);
        end else begin
          want = pending_tokens.pop_front();
          if (got != want) report_mismatch("token mismatch", want, got);
          else if (m_axis_tdata_o[stscan_pkg::OutDataBits-1:PadLsb] != '0)
            report_mismatch("nonzero tdata padding", want, got);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        scan_byte(s_axis_tdata_i, s_axis_tlast_i);
        bytes_accepted++;
      end
      m_axis_tready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog: too long without any transfer means the block hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: %0d cycles without a transfer", StallLimit);
        $display("source_token_scanner_test NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] c);
    source_bytes.push_back('{ch: c, eoi: 1'b0});
    bytes_queued++;
  endtask

  // end of input: the data byte is don't-care, so it is random
  task automatic push_end();
    source_bytes.push_back('{ch: 8'($urandom_range(255)), eoi: 1'b1});
    bytes_queued++;
    sources_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_punct();
    case ($urandom_range(9))
      0: return ChLParen;
      1: return ChRParen;
      2: return ChLBrace;
      3: return ChRBrace;
      4: return ChComma;
      5: return ChDot;
      6: return ChMinus;
      7: return ChPlus;
      8: return ChSemi;
      default: return ChStar;
    endcase
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(3))
      0: return ChSpace;
      1: return ChTab;
      2: return ChCr;
      default: return ChNewline;
    endcase
  endfunction

  function automatic logic [7:0] rand_alpha();
    int unsigned r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return ChUnder;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(ChZero + $urandom_range(9));
  endfunction

  // One source: a run of random lexemes and noise bytes, sometimes cut short by the end.
  task automatic push_random_source();
    int unsigned n_lex;
    logic        at_end;
    logic [7:0]  b;
    n_lex = $urandom_range(1, 8);
    for (int i = 0; i < n_lex; i++) begin
      at_end = (i == n_lex - 1);
      case ($urandom_range(9)) inside
        0: push_byte(rand_punct());
        1: begin
          case ($urandom_range(3))
            0: push_byte(ChBang);
            1: push_byte(ChEqual);
            2: push_byte(ChLess);
            default: push_byte(ChGreater);
          endcase
          if ($urandom_range(1)) push_byte(ChEqual);
        end
        2: begin
          push_byte(ChSlash);
          if ($urandom_range(1)) begin
            push_byte(ChSlash);
            repeat ($urandom_range(0, 5)) begin
              b = 8'($urandom_range(255));
              push_byte(b == ChNewline ? ChSpace : b);
            end
            if (!(at_end && $urandom_range(1))) push_byte(ChNewline);
          end
        end
        3: begin
          push_byte(ChQuote);
          repeat ($urandom_range(0, 6)) begin
            b = ($urandom_range(3) == 0) ? ChNewline : 8'($urandom_range(255));
            push_byte(b == ChQuote ? ChSpace : b);
          end
          if (!(at_end && $urandom_range(1))) push_byte(ChQuote);
        end
        4, 5: begin
          repeat ($urandom_range(1, 4)) push_byte(rand_digit());
          case ($urandom_range(2))
            0: ;
            1: begin
              push_byte(ChDot);
              repeat ($urandom_range(1, 3)) push_byte(rand_digit());
            end
            default: push_byte(ChDot);   // dot with no fraction digit
          endcase
        end
        6, 7: begin
          push_byte(rand_alpha());
          repeat ($urandom_range(0, 4))
            push_byte($urandom_range(3) == 0 ? rand_digit() : rand_alpha());
        end
        8: repeat ($urandom_range(1, 3)) push_byte(rand_space());
        default: push_byte(8'($urandom_range(255)));   // noise
      endcase
      if ($urandom_range(1)) push_byte(rand_space());
    end
    push_end();
  endtask

  task automatic push_random_sources(input int unsigned n_items);
    int unsigned goal;
    goal = bytes_queued + n_items;
    while (bytes_queued < goal) push_random_source();
  endtask

  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || pending_tokens.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // phase 1: sender idles 37%, receiver 54%
    snd_idle_pct = 37;
    rcv_idle_pct = 54;
    // every punctuation form, every operator form but a lone =, ident, number
    // with and without fraction (dot without digit gives three tokens), zero and
    // 0xFF bytes, string left open across a line at end of input
    push_text("){},-+;*!!=<<=>>===_Z9 1.(2.5/");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(ChQuote);
    push_byte("q");
    push_byte(ChNewline);
    push_end();
    // dot without fraction flushed by end of input
    push_text("2.");
    push_end();
    // comment open at end of input: only the end token
    push_text("//");
    push_end();
    push_random_sources(40);
    wait_drained();

    // phase 2: roles swapped
    snd_idle_pct = 54;
    rcv_idle_pct = 37;
    push_random_sources(40);
    wait_drained();

    // phase 3: back to back on both sides
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    push_random_sources(40);
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    $display("Covered %0d source bytes in %0d sources and %0d tokens, %0d mismatches.",
             bytes_accepted, sources_sent, tokens_checked, err_count);
    $display("Included idle/stall mixes both ways and back-to-back traffic.");
    if (err_count == 0 && pending_tokens.size() == 0) begin
      $display("source_token_scanner_test OK");
    end else begin
      $display("source_token_scanner_test NOT OK");
    end
    $finish;
  end

endmodule
